FILE: rtl/cfd_pkg.sv
// ---------------------------------------------------------------------------
// cfd_pkg - command frame deframer shared definitions
// Opcodes, decoder phases, event kinds and the result record.
// ---------------------------------------------------------------------------
package cfd_pkg;

   // Opcode bytes that open a frame
   localparam logic [7:0] OP_DATA   = 8'h01;
   localparam logic [7:0] OP_RESIZE = 8'h02;
   localparam logic [7:0] OP_CLOSE  = 8'h03;

   // Header byte index of the last header byte (four header bytes)
   localparam logic [1:0] HDR_LAST = 2'd3;

   // Event kinds on the result channel
   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_RESIZE  = 2'd1;
   localparam logic [1:0] EV_CLOSE   = 2'd2;

   // Decoder phase
   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_DATA_HDR   = 2'd1,
      PH_RESIZE_HDR = 2'd2,
      PH_PAYLOAD    = 2'd3
   } phase_type;

   // One decoded event
   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  payload_byte;
      logic        last_of_frame;
      logic [15:0] columns;
      logic [15:0] row_count;
   } rsp_type;

endpackage

FILE: rtl/cfd_decode.sv
// ---------------------------------------------------------------------------
// cfd_decode - frame decoder
// Holds the frame state and decodes one stream byte per advance.
// ---------------------------------------------------------------------------
module cfd_decode (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [7:0]      stream_byte,
   output logic            has_result,
   output cfd_pkg::rsp_type result
);

   cfd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [31:0] header_shift_ff, header_shift_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] shifted;
   logic [31:0] remaining_dec;

   // Hold state; update only when an item advances
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= cfd_pkg::PH_IDLE;
         header_count_ff <= 2'd0;
         header_shift_ff <= 32'd0;
         remaining_ff    <= 32'd0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         header_shift_ff <= header_shift_in;
         remaining_ff    <= remaining_in;
      end
   end

   assign shifted       = {header_shift_ff[23:0], stream_byte};
   assign remaining_dec = remaining_ff - 32'd1;

   // Next state and result for the current byte
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      header_shift_in = header_shift_ff;
      remaining_in    = remaining_ff;
      has_result      = 1'b0;
      result          = '0;
      unique case (phase_ff)
         cfd_pkg::PH_IDLE: begin
            header_count_in = 2'd0;
            header_shift_in = 32'd0;
            if (stream_byte == cfd_pkg::OP_DATA) begin
               phase_in = cfd_pkg::PH_DATA_HDR;
            end else if (stream_byte == cfd_pkg::OP_RESIZE) begin
               phase_in = cfd_pkg::PH_RESIZE_HDR;
            end else if (stream_byte == cfd_pkg::OP_CLOSE) begin
               has_result        = 1'b1;
               result.event_kind = cfd_pkg::EV_CLOSE;
            end
         end
         cfd_pkg::PH_DATA_HDR,
         cfd_pkg::PH_RESIZE_HDR: begin
            header_shift_in = shifted;
            header_count_in = header_count_ff + 2'd1;
            if (header_count_ff == cfd_pkg::HDR_LAST) begin
               if (phase_ff == cfd_pkg::PH_RESIZE_HDR) begin
                  phase_in          = cfd_pkg::PH_IDLE;
                  has_result        = 1'b1;
                  result.event_kind = cfd_pkg::EV_RESIZE;
                  result.columns    = shifted[31:16];
                  result.row_count  = shifted[15:0];
               end else begin
                  // Drop zero-length frames without a result
                  remaining_in = shifted;
                  phase_in     = (shifted == 32'd0) ? cfd_pkg::PH_IDLE
                                                    : cfd_pkg::PH_PAYLOAD;
               end
            end
         end
         cfd_pkg::PH_PAYLOAD: begin
            if (remaining_ff == 32'd0) begin
               phase_in = cfd_pkg::PH_IDLE;
            end else begin
               remaining_in         = remaining_dec;
               has_result           = 1'b1;
               result.event_kind    = cfd_pkg::EV_PAYLOAD;
               result.payload_byte  = stream_byte;
               result.last_of_frame = (remaining_dec == 32'd0);
               if (remaining_dec == 32'd0) begin
                  phase_in = cfd_pkg::PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = cfd_pkg::PH_IDLE;
         end
      endcase
   end

   // A payload event comes only from the payload phase
   a_payload_phase: assert property (@(posedge clock) disable iff (reset)
      (has_result && result.event_kind == cfd_pkg::EV_PAYLOAD)
         |-> phase_ff == cfd_pkg::PH_PAYLOAD)
      else $error("payload event outside payload phase");

   // The last flag marks the final due byte
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (has_result && result.last_of_frame) |-> remaining_ff == 32'd1)
      else $error("last flag with bytes still due");

   // A resize event needs a full header
   a_resize_hdr: assert property (@(posedge clock) disable iff (reset)
      (has_result && result.event_kind == cfd_pkg::EV_RESIZE)
         |-> header_count_ff == cfd_pkg::HDR_LAST)
      else $error("resize event before header complete");

   // Reset returns to awaiting an opcode
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> phase_ff == cfd_pkg::PH_IDLE)
      else $error("phase not idle after reset");

endmodule

FILE: rtl/cfd_out_reg.sv
// ---------------------------------------------------------------------------
// cfd_out_reg - result register
// Holds one decoded event until the result channel takes it.
// ---------------------------------------------------------------------------
module cfd_out_reg (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  logic            load_valid,
   input  cfd_pkg::rsp_type load_data,
   output logic            can_load,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output cfd_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   cfd_pkg::rsp_type data_ff;

   // Free when empty or when the held item leaves this cycle
   assign can_load = !valid_ff || rsp_ready;

   // Load a new item or drain the taken one
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= load_valid;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Capture payload on load only
   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // Loading is only allowed while the register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("result register overwritten");

   // A held item that is not taken stays unchanged
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(data_ff)))
      else $error("held result changed");

   // An empty load leaves nothing behind
   a_empty_load: assert property (@(posedge clock) disable iff (reset)
      (load && !load_valid) |=> !valid_ff)
      else $error("result without decoded event");

endmodule

FILE: rtl/command_frame_deframer.sv
// ---------------------------------------------------------------------------
// command_frame_deframer - byte stream command frame decoder
// Decodes data, resize and close frames into payload and control events.
//
//   channel | ports                          | direction | width
//   --------+--------------------------------+-----------+------------------
//   req     | req_valid/ready, stream_byte   | in        | 8
//   rsp     | rsp_valid/ready, event fields  | out       | 2+8+1+16+16
//
// One byte is taken every cycle while the result side keeps up.
// A byte moves from the input register to the result register once free.
// The input register and the result register each hold one item, so a
// result stall backs up through req_ready one stage at a time.
// Synchronous reset empties both registers and returns to awaiting opcode.
// ---------------------------------------------------------------------------
module command_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_frame,
   output logic [15:0] rsp_columns,
   output logic [15:0] rsp_row_count
);

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             advance;
   logic             out_free;
   logic             has_result;
   cfd_pkg::rsp_type result;
   cfd_pkg::rsp_type rsp_data;

   // Advance the held byte when the result register can take it
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   cfd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .stream_byte (in_byte_ff),
      .has_result  (has_result),
      .result      (result)
   );

   cfd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (has_result),
      .load_data  (result),
      .can_load   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_event_kind    = rsp_data.event_kind;
   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_last_of_frame = rsp_data.last_of_frame;
   assign rsp_columns       = rsp_data.columns;
   assign rsp_row_count     = rsp_data.row_count;

endmodule
